FILE: hdl/brb_pkg.sv
package brb_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 7;
  localparam int PEND_W    = 8;
  localparam int RSIZE_W   = 9;
  localparam int OP_W      = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Defaults for the top level parameters
  localparam int DEPTH_DEF     = 256;
  localparam int MAX_COUNT_DEF = 64;

  // Ring size register reset value
  localparam logic [RSIZE_W-1:0] RSIZE_RST = 9'd256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_READ     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OP_W-1:0] OP_DISCARD  = 3'd3;
  localparam logic [OP_W-1:0] OP_READLINE = 3'd4;

  // Line terminators
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

  // Register write from the config port to the controller
  typedef struct packed {
    logic               wr;
    logic [RSIZE_W-1:0] size;
  } cfg_t;

  function automatic logic is_term(input logic [BYTE_W-1:0] c);
    is_term = (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

FILE: hdl/byte_ring_buffer_with_line_read_unit.sv
// Byte ring buffer with line read.
// Input channel (in_valid/in_stall) carries one operation word: in_op selects
// add, read, peek, discard or readline, in_byte is the byte to add and
// in_count the byte limit (line buffer length for readline).
// Result channel (out_valid/out_stall) returns one word per byte moved by
// read, peek or readline, or a single status word otherwise; out_last marks
// the final word, and pending/full status on every word is after the op.
// The APB port holds ring_size at address 0; writing it empties the ring.
// Sequencing: an op is taken when the controller is idle. Add, discard and
// ops that move no byte return one status word. Read and peek fetch n bytes
// one after another. Readline scans k bytes (k up to count-1), checks the
// byte after a terminator when it lies in the window, then replays a line of
// L bytes. The pace is set by the single registered read port of the byte
// storage.
// When out_stall is high the held result word stays and the sequencer waits
// before loading the next word; a new op can still be taken while the last result word waits.
// Reset (synchronous) empties the ring and sets ring_size to 256; storage
// contents are not cleared.
module byte_ring_buffer_with_line_read_unit #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_COUNT = brb_pkg::MAX_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brb_pkg::APB_AW-1:0]  paddr,
  input  logic [brb_pkg::APB_DW-1:0]  pwdata,
  output logic [brb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::OP_W-1:0]    in_op,
  input  logic [brb_pkg::BYTE_W-1:0]  in_byte,
  input  logic [brb_pkg::COUNT_W-1:0] in_count,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brb_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic [brb_pkg::COUNT_W-1:0] out_done_count,
  output logic                        out_accepted,
  output logic [brb_pkg::PEND_W-1:0]  out_pending,
  output logic                        out_full_res
);

  localparam int AW = $clog2(DEPTH);

  logic [brb_pkg::RSIZE_W-1:0] ring_size_r;
  brb_pkg::cfg_t               cfg;
  logic                        reg_hit;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [brb_pkg::BYTE_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [brb_pkg::BYTE_W-1:0]  mem_rdata;

  // APB register decode: ring_size lives at word 0
  assign pready   = 1'b1;
  assign reg_hit  = !paddr[brb_pkg::APB_AW-1];
  assign cfg.wr   = psel && penable && pwrite && reg_hit;
  assign cfg.size = pwdata[brb_pkg::RSIZE_W-1:0];
  assign prdata   = reg_hit ? brb_pkg::APB_DW'(ring_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= brb_pkg::RSIZE_RST;
    end else if (cfg.wr) begin
      ring_size_r <= cfg.size;
    end
  end

  brb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_COUNT (MAX_COUNT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_byte        (in_byte),
    .in_count       (in_count),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_done_count (out_done_count),
    .out_accepted   (out_accepted),
    .out_pending    (out_pending),
    .out_full_res   (out_full_res)
  );

endmodule

FILE: hdl/brb_ram.sv
module brb_ram #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [brb_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [brb_pkg::BYTE_W-1:0] rdata
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/brb_ctrl.sv
module brb_ctrl #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_COUNT = brb_pkg::MAX_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brb_pkg::cfg_t               cfg,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::OP_W-1:0]    in_op,
  input  logic [brb_pkg::BYTE_W-1:0]  in_byte,
  input  logic [brb_pkg::COUNT_W-1:0] in_count,
  // storage
  output logic                        mem_we,
  output logic [$clog2(DEPTH)-1:0]    mem_waddr,
  output logic [brb_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(DEPTH)-1:0]    mem_raddr,
  input  logic [brb_pkg::BYTE_W-1:0]  mem_rdata,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brb_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic [brb_pkg::COUNT_W-1:0] out_done_count,
  output logic                        out_accepted,
  output logic [brb_pkg::PEND_W-1:0]  out_pending,
  output logic                        out_full_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = brb_pkg::COUNT_W;
  localparam int NW = (SW > CW) ? SW : CW;
  localparam int KW = (SW > brb_pkg::RSIZE_W) ? SW : brb_pkg::RSIZE_W;
  localparam int PW = (SW > brb_pkg::PEND_W) ? SW : brb_pkg::PEND_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SINGLE = 3'd1;
  localparam logic [2:0] S_REQ    = 3'd2;
  localparam logic [2:0] S_DATA   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_TERM2  = 3'd5;

  // Clamp a ring size register value to [2, DEPTH]
  function automatic logic [SW-1:0] clamp_size(input logic [brb_pkg::RSIZE_W-1:0] rs);
    logic [KW-1:0] rk;
    rk = KW'(rs);
    if (rk < KW'(2)) begin
      clamp_size = SW'(2);
    end else if (rk > KW'(DEPTH)) begin
      clamp_size = SW'(DEPTH);
    end else begin
      clamp_size = rk[SW-1:0];
    end
  endfunction

  // Step a position around the ring
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [SW-1:0] s);
    logic [SW-1:0] q;
    q = SW'(p) + SW'(1);
    adv = (q >= s) ? '0 : q[AW-1:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [SW-1:0] size_r;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [CW-1:0] win_r, win_nxt;
  logic [CW-1:0] done_r, done_nxt;
  logic          acc_r, acc_nxt;

  // output word register
  logic                       ov_r;
  logic [brb_pkg::BYTE_W-1:0] ob_r;
  logic                       obv_r;
  logic                       olast_r;
  logic [CW-1:0]              odone_r;
  logic                       oacc_r;
  logic [brb_pkg::PEND_W-1:0] opend_r;
  logic                       ofull_r;

  logic                       ld;
  logic [brb_pkg::BYTE_W-1:0] ld_byte;
  logic                       ld_bv;
  logic                       ld_last;
  logic                       ld_acc;
  logic                       can_load;

  // ring status from the pointers
  logic [SW-1:0]  pend;
  logic [PW-1:0]  pend_x;
  logic           full;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_rl;
  logic [CW-1:0]  win;
  logic [NW-1:0]  pend_n;
  logic [NW-1:0]  nrd_n;
  logic [NW-1:0]  nrl_n;
  logic [CW-1:0]  n_rd;
  logic [CW-1:0]  n_rl;
  logic [NW:0]    rsum;
  logic [NW:0]    rwrap;
  logic [AW-1:0]  rd_after;
  logic [AW-1:0]  pn;
  logic           acc_in;
  logic           fin;
  logic [CW-1:0]  fin_len;

  assign pend   = (rd_r <= wr_r) ? (SW'(wr_r) - SW'(rd_r))
                                 : (size_r - SW'(rd_r) + SW'(wr_r));
  assign pend_x = PW'(pend);
  assign full   = (adv(wr_r, size_r) == rd_r);

  // saturated counts and the byte totals of each operation
  assign cnt    = (in_count > CW'(MAX_COUNT)) ? CW'(MAX_COUNT) : in_count;
  assign cnt_rl = (cnt == '0) ? CW'(1) : cnt;
  assign win    = cnt_rl - CW'(1);
  assign pend_n = NW'(pend);
  assign nrd_n  = (NW'(cnt) < pend_n) ? NW'(cnt) : pend_n;
  assign nrl_n  = (NW'(win) < pend_n) ? NW'(win) : pend_n;
  assign n_rd   = nrd_n[CW-1:0];
  assign n_rl   = nrl_n[CW-1:0];

  // read pointer after consuming n_rd bytes
  assign rsum     = (NW+1)'(rd_r) + (NW+1)'(n_rd);
  assign rwrap    = (rsum >= (NW+1)'(size_r)) ? (rsum - (NW+1)'(size_r)) : rsum;
  assign rd_after = rwrap[AW-1:0];

  assign pn       = adv(p_r, size_r);
  assign in_stall = (state_r != S_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign can_load = !ov_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    p_nxt     = p_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    win_nxt   = win_r;
    done_nxt  = done_r;
    acc_nxt   = acc_r;
    mem_we    = 1'b0;
    mem_waddr = wr_r;
    mem_wdata = in_byte;
    mem_re    = 1'b0;
    mem_raddr = p_r;
    ld        = 1'b0;
    ld_byte   = '0;
    ld_bv     = 1'b0;
    ld_last   = 1'b1;
    ld_acc    = 1'b0;
    fin       = 1'b0;
    fin_len   = '0;

    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          done_nxt  = '0;
          acc_nxt   = 1'b0;
          state_nxt = S_SINGLE;
          case (in_op)
            brb_pkg::OP_ADD: begin
              if (!full) begin
                mem_we  = 1'b1;
                wr_nxt  = adv(wr_r, size_r);
                acc_nxt = 1'b1;
              end
            end
            brb_pkg::OP_READ, brb_pkg::OP_PEEK: begin
              if (n_rd != '0) begin
                // first byte read goes out now, data arrives in S_DATA
                mem_re    = 1'b1;
                mem_raddr = rd_r;
                p_nxt     = rd_r;
                rem_nxt   = n_rd;
                done_nxt  = n_rd;
                state_nxt = S_DATA;
                if (in_op == brb_pkg::OP_READ) begin
                  rd_nxt = rd_after;
                end
              end
            end
            brb_pkg::OP_DISCARD: begin
              rd_nxt   = rd_after;
              done_nxt = n_rd;
            end
            brb_pkg::OP_READLINE: begin
              if (n_rl != '0) begin
                mem_re    = 1'b1;
                mem_raddr = rd_r;
                p_nxt     = rd_r;
                start_nxt = rd_r;
                idx_nxt   = '0;
                lim_nxt   = n_rl;
                win_nxt   = win;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SINGLE: begin
        if (can_load) begin
          ld        = 1'b1;
          ld_acc    = acc_r;
          state_nxt = S_IDLE;
        end
      end

      S_REQ: begin
        mem_re    = 1'b1;
        state_nxt = S_DATA;
      end

      // one byte word per cycle while out_stall is low; next read issued as this one is taken
      S_DATA: begin
        if (can_load) begin
          ld      = 1'b1;
          ld_byte = mem_rdata;
          ld_bv   = 1'b1;
          ld_last = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pn;
            p_nxt     = pn;
            rem_nxt   = rem_r - CW'(1);
          end
        end
      end

      // search the window for a terminator
      S_SCAN: begin
        if (brb_pkg::is_term(mem_rdata)) begin
          if ((idx_r + CW'(1)) < lim_r) begin
            mem_re    = 1'b1;
            mem_raddr = pn;
            p_nxt     = pn;
            state_nxt = S_TERM2;
          end else begin
            rd_nxt  = pn;
            fin     = 1'b1;
            fin_len = idx_r;
          end
        end else if ((idx_r + CW'(1)) == lim_r) begin
          if (lim_r == win_r) begin
            // window full without terminator
            rd_nxt  = pn;
            fin     = 1'b1;
            fin_len = lim_r;
          end else begin
            // incomplete line: nothing consumed
            done_nxt  = '0;
            state_nxt = S_SINGLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pn;
          p_nxt     = pn;
          idx_nxt   = idx_r + CW'(1);
        end
      end

      // swallow a second terminator right after the first
      S_TERM2: begin
        rd_nxt  = brb_pkg::is_term(mem_rdata) ? pn : p_r;
        fin     = 1'b1;
        fin_len = idx_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // line found: replay it from the start position, or send a status word for an empty line
    if (fin) begin
      done_nxt = fin_len;
      if (fin_len == '0) begin
        state_nxt = S_SINGLE;
      end else begin
        rem_nxt   = fin_len;
        p_nxt     = start_r;
        state_nxt = S_REQ;
      end
    end

    // ring size write empties the ring
    if (cfg.wr) begin
      rd_nxt = '0;
      wr_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_r    <= '0;
      wr_r    <= '0;
      size_r  <= clamp_size(brb_pkg::RSIZE_RST);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      if (cfg.wr) begin
        size_r <= clamp_size(cfg.size);
      end
      if (ld) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    start_r <= start_nxt;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    lim_r   <= lim_nxt;
    win_r   <= win_nxt;
    done_r  <= done_nxt;
    acc_r   <= acc_nxt;
  end

  // output word payload; status reflects pointers after the operation
  always_ff @(posedge clk) begin
    if (ld) begin
      ob_r    <= ld_byte;
      obv_r   <= ld_bv;
      olast_r <= ld_last;
      odone_r <= done_r;
      oacc_r  <= ld_acc;
      opend_r <= pend_x[brb_pkg::PEND_W-1:0];
      ofull_r <= full;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;
  assign out_done_count = odone_r;
  assign out_accepted   = oacc_r;
  assign out_pending    = opend_r;
  assign out_full_res   = ofull_r;

endmodule

FILE: hdl/brb_chk.sv
module brb_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [brb_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_byte_valid,
  input logic                        out_last,
  input logic [brb_pkg::COUNT_W-1:0] out_done_count,
  input logic                        out_accepted
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // right after reset the block is idle and empty-handed
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a byte word always reports a nonzero total
  a_byte_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_done_count != '0)
    else $error("byte word with zero total");

  // status words carry no byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == '0 && out_last)
    else $error("status word malformed");

  // a stored add is a lone status word
  a_add_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> !out_byte_valid && out_done_count == '0)
    else $error("accepted flag on a non-add word");

endmodule

bind byte_ring_buffer_with_line_read_unit brb_chk u_brb_chk (.*);
